@@ rtl/gtg_pkg.sv @@
package gtg_pkg;

  localparam int PosW    = 20;
  localparam int HeadW   = 15;
  localparam int TolW    = 19;
  localparam int GainW   = 8;
  localparam int LinW    = 24;
  localparam int AngW    = 17;
  localparam int DiffW   = 21;
  localparam int SqW     = 43;
  localparam int RootW   = 22;
  localparam int CordW   = 33;
  localparam int ZW      = 21;
  localparam int SinW    = 27;
  localparam int AtanEntries = 24;
  localparam int SqrtSteps   = 22;

  localparam logic signed [ZW-1:0] PiQ16     = 21'sd205887;
  localparam logic signed [ZW-1:0] TwoPiQ16  = 21'sd411775;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 21'sd102944;
  localparam logic signed [SinW-1:0] CordicK = 27'sd10188014;
  localparam logic signed [SinW-1:0] OneQ24  = 27'sd16777216;

  localparam logic [2:0] RegGoalX = 3'd0;
  localparam logic [2:0] RegGoalY = 3'd1;
  localparam logic [2:0] RegTol   = 3'd2;
  localparam logic [2:0] RegLinG  = 3'd3;
  localparam logic [2:0] RegAngG  = 3'd4;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [HeadW-1:0] heading;
  } pose_t;

  typedef struct packed {
    logic [LinW-1:0] linear_vel;
    logic [AngW-1:0] angular_vel;
    logic            arrived;
  } cmd_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 21'sd51472;  1: r = 21'sd30386;  2: r = 21'sd16055;  3: r = 21'sd8150;
      4: r = 21'sd4091;   5: r = 21'sd2047;   6: r = 21'sd1024;   7: r = 21'sd512;
      8: r = 21'sd256;    9: r = 21'sd128;    10: r = 21'sd64;    11: r = 21'sd32;
      12: r = 21'sd16;    13: r = 21'sd8;     14: r = 21'sd4;     15: r = 21'sd2;
      16: r = 21'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/gtg_stream_if.sv @@
interface gtg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gtg_vec_cell.sv @@
// one vectoring cordic step per cell
module gtg_vec_cell
  import gtg_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CordW-1:0]  x_i,
  input  logic signed [CordW-1:0]  y_i,
  input  logic signed [ZW-1:0]     z_i,
  output logic signed [CordW-1:0]  x_o,
  output logic signed [CordW-1:0]  y_o,
  output logic signed [ZW-1:0]     z_o
);
  logic signed [CordW-1:0] x_d, y_d;
  logic signed [ZW-1:0]    z_d;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> Idx);
      y_d = y_i - (x_i >>> Idx);
      z_d = z_i + atan_q16(Idx);
    end else begin
      x_d = x_i - (y_i >>> Idx);
      y_d = y_i + (x_i >>> Idx);
      z_d = z_i - atan_q16(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end
endmodule

@@ rtl/gtg_rot_cell.sv @@
// one rotation cordic step toward the sine
module gtg_rot_cell
  import gtg_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SinW-1:0]  x_i,
  input  logic signed [SinW-1:0]  y_i,
  input  logic signed [ZW-1:0]    z_i,
  output logic signed [SinW-1:0]  x_o,
  output logic signed [SinW-1:0]  y_o,
  output logic signed [ZW-1:0]    z_o
);
  logic signed [SinW-1:0] x_d, y_d;
  logic signed [ZW-1:0]   z_d;

  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - (y_i >>> Idx);
      y_d = y_i + (x_i >>> Idx);
      z_d = z_i - atan_q16(Idx);
    end else begin
      x_d = x_i + (y_i >>> Idx);
      y_d = y_i - (x_i >>> Idx);
      z_d = z_i + atan_q16(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end
endmodule

@@ rtl/gtg_sqrt_cell.sv @@
// one restoring square-root digit per cell
module gtg_sqrt_cell
  import gtg_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SqW-1:0]     rem_i,
  input  logic [RootW-1:0]   root_i,
  output logic [SqW-1:0]     rem_o,
  output logic [RootW-1:0]   root_o
);
  localparam int Sh = 2 * (SqrtSteps - 1 - Idx);
  logic [SqW+1:0] trial;
  logic [SqW+1:0] cand;

  always_comb begin
    cand  = ({{(SqW+2-RootW){1'b0}}, root_i} << (Sh + 2))
          | ({{(SqW+1){1'b0}}, 1'b1} << Sh);
    trial = {2'b0, rem_i} - cand;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if ({2'b0, rem_i} >= cand) begin
        rem_o  <= trial[SqW-1:0];
        root_o <= {root_i[RootW-2:0], 1'b1};
      end else begin
        rem_o  <= rem_i;
        root_o <= {root_i[RootW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/go_to_goal_p_controller.sv @@
// an accepted pose word passes through these registered stages in order to the result word
// (difference, square, bearing cordic chain, wrap/fold, sine cordic chain, gain, output)
// throughput: one word per cycle while the chain advances; the whole chain of cells advances when the output
// register is free or being taken
// reset: valid bits clear; registers return to goal (0,0), tolerance 41, gains 16 and 64
module go_to_goal_p_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtg_stream_if.sink   pose_in,
  gtg_stream_if.source cmd_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int N = CORDIC_ITERATIONS;
  // stages: 0 diff, 1 square, 2..N+1 vectoring (sqrt runs alongside), N+2 wrap,
  // N+3..2N+2 rotation, 2N+3 scale, 2N+4 output
  localparam int Depth = 2 * N + 5;

  logic signed [PosW-1:0] goal_x_q, goal_y_q;
  logic [TolW-1:0]  tol_q;
  logic [GainW-1:0] lin_g_q, ang_g_q;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      tol_q    <= 19'd41;
      lin_g_q  <= 8'd16;
      ang_g_q  <= 8'd64;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegGoalX: goal_x_q <= pwdata[PosW-1:0];
        RegGoalY: goal_y_q <= pwdata[PosW-1:0];
        RegTol:   tol_q    <= pwdata[TolW-1:0];
        RegLinG:  lin_g_q  <= pwdata[GainW-1:0];
        RegAngG:  ang_g_q  <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegGoalX: prdata = {{(32-PosW){goal_x_q[PosW-1]}}, goal_x_q};
      RegGoalY: prdata = {{(32-PosW){goal_y_q[PosW-1]}}, goal_y_q};
      RegTol:   prdata = {{(32-TolW){1'b0}}, tol_q};
      RegLinG:  prdata = {24'd0, lin_g_q};
      RegAngG:  prdata = {24'd0, ang_g_q};
      default:  prdata = '0;
    endcase
  end

  // pipeline advance
  logic [Depth-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[Depth-1] || cmd_out.ready;
  assign pose_in.ready = adv;
  assign cmd_out.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], pose_in.valid};
  end

  // stage 0: differences
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [HeadW-1:0] hd_q [0:N+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= DiffW'(goal_x_q) - DiffW'($signed(pose_in.data.pos_x));
      dy_q <= DiffW'(goal_y_q) - DiffW'($signed(pose_in.data.pos_y));
      hd_q[0] <= pose_in.data.heading;
      for (int k = 1; k < N + 2; k++) hd_q[k] <= hd_q[k-1];
    end
  end

  // stage 1: square sum and cordic pre-rotation
  logic [SqW-1:0] d2_q;
  logic signed [CordW-1:0] vx [0:N];
  logic signed [CordW-1:0] vy [0:N];
  logic signed [ZW-1:0]    vz [0:N];
  logic signed [2*DiffW-1:0] sqx, sqy;
  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q <= SqW'(sqx) + SqW'(sqy);
      if (dx_q < 0) begin
        vx[0] <= -(CordW'(dx_q) <<< 8);
        vy[0] <= -(CordW'(dy_q) <<< 8);
        vz[0] <= (dy_q >= 0) ? PiQ16 : -PiQ16;
      end else begin
        vx[0] <= CordW'(dx_q) <<< 8;
        vy[0] <= CordW'(dy_q) <<< 8;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gtg_vec_cell #(.Idx(i)) u_cell (
      .clk_i, .en_i(adv),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  // square root chain runs beside the vectoring chain and finishes alongside it
  localparam int SqPer = (SqrtSteps + N - 1) / N;
  localparam int SqTot = SqPer * N;
  logic [SqW-1:0]   rem [0:SqTot];
  logic [RootW-1:0] root [0:SqTot];
  assign rem[0]  = d2_q;
  assign root[0] = '0;
  for (genvar j = 0; j < SqTot; j++) begin : g_sq
    if (j < SqrtSteps) begin : g_dig
      if ((j % SqPer) == SqPer - 1) begin : g_reg
        gtg_sqrt_cell #(.Idx(j)) u_cell (
          .clk_i, .en_i(adv), .rem_i(rem[j]), .root_i(root[j]),
          .rem_o(rem[j+1]), .root_o(root[j+1])
        );
      end else begin : g_comb
        localparam int Sh = 2 * (SqrtSteps - 1 - j);
        logic [SqW+1:0] cand;
        assign cand = ({{(SqW+2-RootW){1'b0}}, root[j]} << (Sh + 2))
                    | ({{(SqW+1){1'b0}}, 1'b1} << Sh);
        assign rem[j+1]  = ({2'b0, rem[j]} >= cand) ? SqW'({2'b0, rem[j]} - cand) : rem[j];
        assign root[j+1] = {root[j][RootW-2:0], ({2'b0, rem[j]} >= cand)};
      end
    end else if ((j % SqPer) == SqPer - 1) begin : g_pass
      logic [SqW-1:0] r_q;
      logic [RootW-1:0] t_q;
      always_ff @(posedge clk_i) if (adv) begin
        r_q <= rem[j];
        t_q <= root[j];
      end
      assign rem[j+1] = r_q;
      assign root[j+1] = t_q;
    end else begin : g_wire
      assign rem[j+1] = rem[j];
      assign root[j+1] = root[j];
    end
  end

  // distance carried along the rotation chain
  logic [RootW-1:0] dist_q [0:N+1];
  assign dist_q[0] = root[SqTot];
  for (genvar k = 0; k <= N; k++) begin : g_dist
    always_ff @(posedge clk_i) if (adv) dist_q[k+1] <= dist_q[k];
  end

  // stage N+2: wrap and fold the bearing error
  logic signed [ZW+1:0] e0, e1;
  logic signed [ZW-1:0] err;
  always_comb begin
    e0 = (ZW+2)'(vz[N]) - ((ZW+2)'(hd_q[N+1]) <<< 4);
    if (e0 > (ZW+2)'(PiQ16)) e1 = e0 - (ZW+2)'(TwoPiQ16);
    else if (e0 < -(ZW+2)'(PiQ16)) e1 = e0 + (ZW+2)'(TwoPiQ16);
    else e1 = e0;
    if (e1 > (ZW+2)'(HalfPiQ16)) err = ZW'((ZW+2)'(PiQ16) - e1);
    else if (e1 < -(ZW+2)'(HalfPiQ16)) err = ZW'(-(ZW+2)'(PiQ16) - e1);
    else err = ZW'(e1);
  end

  logic signed [SinW-1:0] rx [0:N];
  logic signed [SinW-1:0] ry [0:N];
  logic signed [ZW-1:0]   rz [0:N];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx[0] <= CordicK;
      ry[0] <= '0;
      rz[0] <= err;
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_rot
    gtg_rot_cell #(.Idx(i)) u_cell (
      .clk_i, .en_i(adv),
      .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1])
    );
  end

  // stage 2N+3: gains
  logic signed [SinW-1:0] s_c;
  assign s_c = (ry[N] > OneQ24) ? OneQ24 : ((ry[N] < -OneQ24) ? -OneQ24 : ry[N]);
  logic [RootW+GainW-1:0] lin_prod_q;
  logic signed [SinW+GainW:0] ang_prod_q;
  logic arr_q;
  logic [RootW-1:0] dist_n;
  assign dist_n = dist_q[N+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_prod_q <= dist_n * lin_g_q;
      ang_prod_q <= s_c * $signed({1'b0, ang_g_q});
      arr_q <= ({{(RootW-TolW){1'b0}}, tol_q} >= dist_n);
    end
  end

  // stage 2N+4: saturate into the output register
  logic [RootW+GainW-5:0] lin_s;
  logic signed [SinW+GainW-16:0] ang_s;
  assign lin_s = lin_prod_q[RootW+GainW-1:4];
  assign ang_s = ang_prod_q[SinW+GainW:16];
  cmd_t cmd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (arr_q) begin
        cmd_q <= '{linear_vel: '0, angular_vel: '0, arrived: 1'b1};
      end else begin
        cmd_q.arrived <= 1'b0;
        cmd_q.linear_vel <= (lin_s > (RootW+GainW-4)'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                 : lin_s[LinW-1:0];
        if (ang_s > 20'sd65535) cmd_q.angular_vel <= 17'h0FFFF;
        else if (ang_s < -20'sd65536) cmd_q.angular_vel <= 17'h10000;
        else cmd_q.angular_vel <= ang_s[AngW-1:0];
      end
    end
  end
  assign cmd_out.data = cmd_q;
endmodule
